>>> rtl/core/rqd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready queue package
// Shared types and constants for the ready queue front end, engine and queues.
// ----------------------------------------------------------------------------
package rqd_pkg;

	localparam int ID_W      = 4;
	localparam int CNT_OUT_W = 5;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_POP,
		OP_SKIP
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [ID_W-1:0] pid;
		logic            at_front;
	} cmd_t;

	typedef struct packed {
		logic [ID_W-1:0]      popped_id;
		logic                 popped_valid;
		logic                 was_empty;
		logic [CNT_OUT_W-1:0] queue_count;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UNLINK,
		ST_INS,
		ST_FIX,
		ST_OUT
	} state_t;

endpackage

>>> rtl/core/rqd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready queue FIFO
// Small first-in first-out buffer used between the stages of the ready queue.
// ----------------------------------------------------------------------------
module rqd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> rtl/core/rqd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready queue front end
// Accepts request transactions, decodes them into commands and buffers them.
// ----------------------------------------------------------------------------
module rqd_front #(
	parameter int MAX_PROCS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          mode,
	input  logic [rqd_pkg::ID_W-1:0]      proc_id,
	input  logic                          at_front,
	output logic                          cmd_valid,
	output rqd_pkg::cmd_t                 cmd,
	input  logic                          cmd_take
);

	rqd_pkg::cmd_t dec;
	logic          cmd_empty;

	always_comb begin
		dec.pid      = proc_id;
		dec.at_front = at_front;
		if (mode) begin
			dec.op = rqd_pkg::OP_POP;
		end else if (int'(proc_id) < MAX_PROCS) begin
			dec.op = rqd_pkg::OP_ADD;
		end else begin
			dec.op = rqd_pkg::OP_SKIP;
		end
	end

	rqd_fifo #(
		.WIDTH ($bits(rqd_pkg::cmd_t)),
		.DEPTH (2)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (dec),
		.full    (full),
		.rd_en   (cmd_take),
		.rd_data (cmd),
		.empty   (cmd_empty)
	);

	assign cmd_valid = !cmd_empty;

endmodule

>>> rtl/core/rqd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready queue engine
// Walks the link tables one step a cycle, unless stalled: unlink, insert, pop.
// ----------------------------------------------------------------------------
module rqd_back #(
	parameter int MAX_PROCS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  rqd_pkg::cmd_t cmd,
	output logic          cmd_take,
	output logic          res_push,
	output rqd_pkg::res_t res,
	input  logic          res_full
);

	localparam int IW   = $clog2(MAX_PROCS + 1);
	localparam int PW   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNTW = (IW > rqd_pkg::CNT_OUT_W) ? IW : rqd_pkg::CNT_OUT_W;
	localparam int IDW  = rqd_pkg::ID_W;
	localparam logic [IW-1:0] SENT = IW'(MAX_PROCS);

	rqd_pkg::state_t state_q, state_d;
	logic [IW-1:0]        p_q, p_d;
	logic                 front_q, front_d;
	logic                 pop_q, pop_d;
	logic                 wl_q, wl_d;
	logic                 wempty_q, wempty_d;
	logic [IW-1:0]        head_q, head_d;
	logic [IW-1:0]        tail_q, tail_d;
	logic [CNTW-1:0]      count_q, count_d;
	logic [MAX_PROCS-1:0] linked_q, linked_d;
	logic                 fix_en_q, fix_en_d;
	logic [IW-1:0]        fix_idx_q, fix_idx_d;
	rqd_pkg::res_t        res_q, res_d;

	logic [IW-1:0] next_mem [MAX_PROCS];
	logic [IW-1:0] prev_mem [MAX_PROCS];
	logic [IW-1:0] next_rd_q;
	logic [IW-1:0] prev_rd_q;

	logic          rd_en;
	logic [PW-1:0] rd_a;
	logic          nx_we;
	logic [PW-1:0] nx_wa;
	logic [IW-1:0] nx_wd;
	logic          pv_we;
	logic [PW-1:0] pv_wa;
	logic [IW-1:0] pv_wd;
	logic          empty_now;
	logic [IW-1:0] pid_idx;

	assign empty_now = (head_q == SENT);
	assign pid_idx   = IW'(cmd.pid);
	assign rd_a      = p_d[PW-1:0];
	assign res       = res_q;

	always_comb begin
		state_d   = state_q;
		p_d       = p_q;
		front_d   = front_q;
		pop_d     = pop_q;
		wl_d      = wl_q;
		wempty_d  = wempty_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		linked_d  = linked_q;
		fix_en_d  = fix_en_q;
		fix_idx_d = fix_idx_q;
		res_d     = res_q;
		cmd_take  = 1'b0;
		res_push  = 1'b0;
		rd_en     = 1'b0;
		nx_we     = 1'b0;
		nx_wa     = '0;
		nx_wd     = '0;
		pv_we     = 1'b0;
		pv_wa     = '0;
		pv_wd     = '0;
		case (state_q)
			rqd_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					wempty_d = empty_now;
					front_d  = cmd.at_front;
					pop_d    = (cmd.op == rqd_pkg::OP_POP);
					case (cmd.op)
						rqd_pkg::OP_POP: begin
							if (empty_now) begin
								res_d.popped_id    = '0;
								res_d.popped_valid = 1'b0;
								res_d.was_empty    = 1'b1;
								res_d.queue_count  = count_q[rqd_pkg::CNT_OUT_W-1:0];
								state_d            = rqd_pkg::ST_OUT;
							end else begin
								p_d     = head_q;
								wl_d    = 1'b1;
								rd_en   = 1'b1;
								state_d = rqd_pkg::ST_UNLINK;
							end
						end
						rqd_pkg::OP_ADD: begin
							p_d  = pid_idx;
							wl_d = linked_q[pid_idx[PW-1:0]];
							if (linked_q[pid_idx[PW-1:0]]) begin
								rd_en   = 1'b1;
								state_d = rqd_pkg::ST_UNLINK;
							end else begin
								state_d = rqd_pkg::ST_INS;
							end
						end
						default: begin
							res_d.popped_id    = '0;
							res_d.popped_valid = 1'b0;
							res_d.was_empty    = empty_now;
							res_d.queue_count  = count_q[rqd_pkg::CNT_OUT_W-1:0];
							state_d            = rqd_pkg::ST_OUT;
						end
					endcase
				end
			end
			rqd_pkg::ST_UNLINK: begin
				if (next_rd_q == SENT) begin
					tail_d = prev_rd_q;
				end else begin
					pv_we = 1'b1;
					pv_wa = next_rd_q[PW-1:0];
					pv_wd = prev_rd_q;
				end
				if (prev_rd_q == SENT) begin
					head_d = next_rd_q;
				end else begin
					nx_we = 1'b1;
					nx_wa = prev_rd_q[PW-1:0];
					nx_wd = next_rd_q;
				end
				linked_d[p_q[PW-1:0]] = 1'b0;
				if (pop_q) begin
					count_d            = count_q - 1'b1;
					res_d.popped_id    = IDW'(p_q);
					res_d.popped_valid = 1'b1;
					res_d.was_empty    = wempty_q;
					res_d.queue_count  = count_d[rqd_pkg::CNT_OUT_W-1:0];
					state_d            = rqd_pkg::ST_OUT;
				end else begin
					state_d = rqd_pkg::ST_INS;
				end
			end
			rqd_pkg::ST_INS: begin
				nx_we = 1'b1;
				nx_wa = p_q[PW-1:0];
				pv_we = 1'b1;
				pv_wa = p_q[PW-1:0];
				if (front_q) begin
					nx_wd  = head_q;
					pv_wd  = SENT;
					head_d = p_q;
					if (head_q == SENT) begin
						tail_d   = p_q;
						fix_en_d = 1'b0;
					end else begin
						fix_en_d = 1'b1;
					end
					fix_idx_d = head_q;
				end else begin
					nx_wd  = SENT;
					pv_wd  = tail_q;
					tail_d = p_q;
					if (tail_q == SENT) begin
						head_d   = p_q;
						fix_en_d = 1'b0;
					end else begin
						fix_en_d = 1'b1;
					end
					fix_idx_d = tail_q;
				end
				linked_d[p_q[PW-1:0]] = 1'b1;
				if (!wl_q) begin
					count_d = count_q + 1'b1;
				end
				state_d = rqd_pkg::ST_FIX;
			end
			rqd_pkg::ST_FIX: begin
				if (fix_en_q) begin
					if (front_q) begin
						pv_we = 1'b1;
						pv_wa = fix_idx_q[PW-1:0];
						pv_wd = p_q;
					end else begin
						nx_we = 1'b1;
						nx_wa = fix_idx_q[PW-1:0];
						nx_wd = p_q;
					end
				end
				res_d.popped_id    = '0;
				res_d.popped_valid = 1'b0;
				res_d.was_empty    = wempty_q;
				res_d.queue_count  = count_q[rqd_pkg::CNT_OUT_W-1:0];
				state_d            = rqd_pkg::ST_OUT;
			end
			rqd_pkg::ST_OUT: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = rqd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rqd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rqd_pkg::ST_IDLE;
			head_q   <= SENT;
			tail_q   <= SENT;
			count_q  <= '0;
			linked_q <= '0;
			fix_en_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			count_q  <= count_d;
			linked_q <= linked_d;
			fix_en_q <= fix_en_d;
		end
	end

	always_ff @(posedge clk) begin
		p_q       <= p_d;
		front_q   <= front_d;
		pop_q     <= pop_d;
		wl_q      <= wl_d;
		wempty_q  <= wempty_d;
		fix_idx_q <= fix_idx_d;
		res_q     <= res_d;
	end

	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_wa] <= nx_wd;
		end
		if (pv_we) begin
			prev_mem[pv_wa] <= pv_wd;
		end
		if (rd_en) begin
			next_rd_q <= next_mem[rd_a];
			prev_rd_q <= prev_mem[rd_a];
		end
	end

endmodule

>>> rtl/core/ready_queue_deque_with_unlink.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready queue with unlink
// Process ready queue held as a doubly linked list in two link tables.
// ----------------------------------------------------------------------------
// Usage: requests enter on a queue-style port (push/full). mode = 0 adds
// proc_id, unlinking it first if it is already queued, then inserts it at
// the head (at_front = 1) or the tail. mode = 1 pops the head. Each request
// yields exactly one result transaction on the output queue port
// (empty/pop): popped_id, popped_valid, was_empty and queue_count.
// A two-entry command buffer decouples the request side from the list
// engine, and a two-entry result buffer decouples the engine from the
// receiver. The engine performs one link-table read or write step per cycle
// while it is not held by a full result buffer: a pop on an empty queue goes
// straight to the output state, a pop reads the links and unlinks the head,
// a new add inserts and then fixes the neighbour's link, and a move unlinks
// before it inserts and fixes. The engine finishes each request before it
// takes the next one from the command buffer.
// Reset empties both buffers and the queue; the link tables need no clearing.
// When the receiver stalls, results collect in the result buffer, then the
// engine holds, and finally full rises on the request side.
module ready_queue_deque_with_unlink #(
	parameter int MAX_PROCS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       mode,
	input  logic [3:0] proc_id,
	input  logic       at_front,
	output logic       empty,
	input  logic       pop,
	output logic [3:0] popped_id,
	output logic       popped_valid,
	output logic       was_empty,
	output logic [4:0] queue_count
);

	logic          cmd_valid;
	rqd_pkg::cmd_t cmd;
	logic          cmd_take;
	logic          res_push;
	logic          res_full;
	rqd_pkg::res_t res_in;
	rqd_pkg::res_t res_out;

	rqd_front #(
		.MAX_PROCS (MAX_PROCS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.proc_id   (proc_id),
		.at_front  (at_front),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	rqd_back #(
		.MAX_PROCS (MAX_PROCS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.res_push  (res_push),
		.res       (res_in),
		.res_full  (res_full)
	);

	rqd_fifo #(
		.WIDTH ($bits(rqd_pkg::res_t)),
		.DEPTH (2)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign popped_id    = res_out.popped_id;
	assign popped_valid = res_out.popped_valid;
	assign was_empty    = res_out.was_empty;
	assign queue_count  = res_out.queue_count;

	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("Result pushed into a full result buffer.");

	a_cmd_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid)
		else $error("Engine took a command that was not present.");

	a_one_per_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> !cmd_take)
		else $error("Engine took two commands in consecutive cycles.");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_in.popped_valid) |-> !res_in.was_empty)
		else $error("Successful pop reported an empty queue.");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready queue testbench
// Sends add, move and pop requests to the ready queue and predicts every
// result with a linked list of its own. Each result transaction is checked
// field by field, in order, with random idle and stall gaps on both handshakes in most phases.
// ----------------------------------------------------------------------------
module testbench;

	localparam int   NUM_PROCS      = 16;
	localparam int   HEAD_SLOT      = NUM_PROCS;
	localparam logic MODE_ADD       = 1'b0;
	localparam logic MODE_POP       = 1'b1;
	localparam int   WATCHDOG_LIMIT = 2000;
	localparam int   DRAIN_CYCLES   = 30;

	typedef enum int {
		IDLE_NONE,
		IDLE_LIGHT,
		IDLE_HEAVY
	} idle_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic       mode;
	logic [3:0] proc_id;
	logic       at_front;
	logic       empty;
	logic       pop;
	logic [3:0] popped_id;
	logic       popped_valid;
	logic       was_empty;
	logic [4:0] queue_count;

	logic [4:0]    link_next [0:NUM_PROCS];
	logic [4:0]    link_prev [0:NUM_PROCS];
	bit            queued [0:NUM_PROCS-1];
	int unsigned   queued_count;
	rqd_pkg::res_t pending_results [$];

	idle_t tx_idle;
	idle_t rx_idle;
	int    rx_stall;
	int    idle_cycles;
	int    n_errors;
	int    n_sent;
	int    n_checked;
	int    n_moves;
	int    n_pop_hits;
	int    n_pop_misses;
	int    peak_count;

	ready_queue_deque_with_unlink #(
		.MAX_PROCS(NUM_PROCS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.mode(mode),
		.proc_id(proc_id),
		.at_front(at_front),
		.empty(empty),
		.pop(pop),
		.popped_id(popped_id),
		.popped_valid(popped_valid),
		.was_empty(was_empty),
		.queue_count(queue_count)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int pick_idle(idle_t kind);
		int r;
		r = $urandom_range(99);
		case (kind)
			IDLE_LIGHT: begin
				if (r < 60)
					return 0;
				else if (r < 94)
					return $urandom_range(1, 3);
				else
					return $urandom_range(8, 40);
			end
			IDLE_HEAVY: begin
				if (r < 35)
					return 0;
				else if (r < 75)
					return $urandom_range(1, 6);
				else
					return $urandom_range(20, 80);
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	function automatic void ready_list_reset();
		for (int i = 0; i <= NUM_PROCS; i++) begin
			link_next[i] = '0;
			link_prev[i] = '0;
		end
		link_next[HEAD_SLOT] = 5'(HEAD_SLOT);
		link_prev[HEAD_SLOT] = 5'(HEAD_SLOT);
		for (int i = 0; i < NUM_PROCS; i++)
			queued[i] = 1'b0;
		queued_count = 0;
	endfunction

	function automatic void unlink_proc(logic [4:0] p);
		logic [4:0] n;
		logic [4:0] q;
		n = link_next[p];
		q = link_prev[p];
		link_prev[n] = q;
		link_next[q] = n;
		link_next[p] = '0;
		link_prev[p] = '0;
		queued[p[3:0]] = 1'b0;
	endfunction

	function automatic rqd_pkg::res_t ready_list_apply(logic m, logic [3:0] id, logic f);
		rqd_pkg::res_t r;
		logic [4:0]    h;
		logic [4:0]    t;
		bit            was_queued;
		r = '0;
		r.was_empty = (link_next[HEAD_SLOT] == HEAD_SLOT);
		if (m == MODE_POP) begin
			if (!r.was_empty) begin
				h = link_next[HEAD_SLOT];
				unlink_proc(h);
				queued_count--;
				r.popped_id = h[3:0];
				r.popped_valid = 1'b1;
				n_pop_hits++;
			end else begin
				n_pop_misses++;
			end
		end else if (id < NUM_PROCS) begin
			was_queued = queued[id];
			if (was_queued) begin
				unlink_proc({1'b0, id});
				n_moves++;
			end
			if (f) begin
				h = link_next[HEAD_SLOT];
				link_next[id] = h;
				link_prev[h] = {1'b0, id};
				link_next[HEAD_SLOT] = {1'b0, id};
				link_prev[id] = 5'(HEAD_SLOT);
			end else begin
				t = link_prev[HEAD_SLOT];
				link_next[t] = {1'b0, id};
				link_prev[id] = t;
				link_prev[HEAD_SLOT] = {1'b0, id};
				link_next[id] = 5'(HEAD_SLOT);
			end
			queued[id] = 1'b1;
			if (!was_queued)
				queued_count++;
		end
		if (int'(queued_count) > peak_count)
			peak_count = int'(queued_count);
		r.queue_count = queued_count[4:0];
		return r;
	endfunction

	task automatic send_item(logic m, logic [3:0] id, logic f);
		int gap;
		gap = pick_idle(tx_idle);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		mode <= m;
		proc_id <= id;
		at_front <= f;
		do
			@(posedge clk);
		while (full);
		pending_results.push_back(ready_list_apply(m, id, f));
		n_sent++;
		@(negedge clk);
	endtask

	task automatic check_field(string name, logic [4:0] exp_v, logic [4:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		rqd_pkg::res_t exp_r;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: result transaction with no request outstanding", $time);
				n_errors++;
			end else begin
				exp_r = pending_results.pop_front();
				check_field("popped_id", 5'(exp_r.popped_id), 5'(popped_id));
				check_field("popped_valid", 5'(exp_r.popped_valid), 5'(popped_valid));
				check_field("was_empty", 5'(exp_r.was_empty), 5'(was_empty));
				check_field("queue_count", exp_r.queue_count, queue_count);
				n_checked++;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_stall > 0) begin
				rx_stall--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				rx_stall = pick_idle(rx_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	task automatic test_empty_pop();
		send_item(MODE_POP, 4'hF, 1'b1);
		send_item(MODE_POP, 4'h0, 1'b0);
	endtask

	task automatic test_single_entry();
		send_item(MODE_ADD, 4'd5, 1'b1);
		send_item(MODE_ADD, 4'd5, 1'b0);
	endtask

	task automatic test_fill_to_capacity();
		for (int i = 0; i < NUM_PROCS; i++) begin
			if (i != 5)
				send_item(MODE_ADD, i[3:0], i[0]);
		end
	endtask

	task automatic test_moves_at_capacity();
		logic [4:0] sel;
		sel = link_next[HEAD_SLOT];
		send_item(MODE_ADD, sel[3:0], 1'b0);
		sel = link_prev[link_prev[HEAD_SLOT]];
		send_item(MODE_ADD, sel[3:0], 1'b1);
		sel = link_next[link_next[link_next[HEAD_SLOT]]];
		send_item(MODE_ADD, sel[3:0], 1'b0);
		send_item(MODE_POP, 4'hA, 1'b1);
		send_item(MODE_POP, 4'h3, 1'b0);
	endtask

	task automatic test_random_traffic(int n_items, idle_t tx, idle_t rx);
		int         sent;
		int         kind;
		int         run;
		logic [3:0] id;
		tx_idle = tx;
		rx_idle = rx;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(99);
			run = $urandom_range(1, 20);
			repeat (run) begin
				if (kind < 30) begin
					// New processes enter until the queue is full, then the adds become moves.
					id = 4'($urandom_range(NUM_PROCS - 1));
					if (queued_count < NUM_PROCS) begin
						while (queued[id])
							id = 4'($urandom_range(NUM_PROCS - 1));
					end
					send_item(MODE_ADD, id, 1'($urandom_range(1)));
				end else if (kind < 55) begin
					id = 4'($urandom_range(NUM_PROCS - 1));
					if (queued_count > 0) begin
						while (!queued[id])
							id = 4'($urandom_range(NUM_PROCS - 1));
					end
					send_item(MODE_ADD, id, 1'($urandom_range(1)));
				end else if (kind < 85) begin
					send_item(MODE_POP, 4'($urandom_range(15)), 1'($urandom_range(1)));
				end else begin
					send_item(1'($urandom_range(1)), 4'($urandom_range(15)),
						1'($urandom_range(1)));
				end
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		mode = MODE_ADD;
		proc_id = '0;
		at_front = 1'b0;
		tx_idle = IDLE_NONE;
		rx_idle = IDLE_NONE;
		rx_stall = 0;
		idle_cycles = 0;
		n_errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_moves = 0;
		n_pop_hits = 0;
		n_pop_misses = 0;
		peak_count = 0;
		ready_list_reset();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle = IDLE_LIGHT;
		rx_idle = IDLE_LIGHT;
		test_empty_pop();
		test_single_entry();
		test_fill_to_capacity();
		test_moves_at_capacity();
		test_random_traffic(500, IDLE_NONE, IDLE_NONE);
		test_random_traffic(700, IDLE_LIGHT, IDLE_LIGHT);
		test_random_traffic(400, IDLE_LIGHT, IDLE_HEAVY);
		test_random_traffic(300, IDLE_HEAVY, IDLE_NONE);
		push <= 1'b0;
		rx_idle = IDLE_NONE;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests and %0d checked results, including %0d moves.",
			n_sent, n_checked, n_moves);
		$display("Pops: %0d returned a process, %0d found the queue empty; peak depth %0d.",
			n_pop_hits, n_pop_misses, peak_count);
		if (n_errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
